/* rtl/clrp_pkg.sv */
`default_nettype none
package clrp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned FIELD_W = 4;
  localparam int unsigned VALUE_W = 63;
  localparam int unsigned LEN_W = 25;
  localparam int unsigned COUNT_W = 21;
  localparam int unsigned MAXLEN_W = 24;
  localparam int unsigned MAXENT_W = 20;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_TIME = 2'd1;
  localparam logic [1:0] KIND_ACCEPT = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [2:0] ERR_TOO_LONG = 3'd0;
  localparam logic [2:0] ERR_TOO_MANY = 3'd1;
  localparam logic [2:0] ERR_TOO_FEW = 3'd2;
  localparam logic [2:0] ERR_AUTHOR_TIME = 3'd3;
  localparam logic [2:0] ERR_COMMIT_TIME = 3'd4;
  localparam logic [2:0] ERR_NONE = 3'd0;

  localparam logic [CFG_IDX_W-1:0] REG_BYTE_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RECORD_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEPARATOR = 2'd2;

  localparam logic [MAXLEN_W-1:0] BYTE_LIMIT_RESET = 24'd65536;
  localparam logic [MAXENT_W-1:0] RECORD_LIMIT_RESET = 20'd4096;
  localparam logic [BYTE_W-1:0] FIELD_SEPARATOR_RESET = 8'd31;

  localparam logic [FIELD_W-1:0] PARENT_FIELD = 4'd1;
  localparam logic [FIELD_W-1:0] AUTHOR_FIELD = 4'd2;
  localparam logic [FIELD_W-1:0] COMMIT_FIELD = 4'd5;

  localparam logic [LEN_W-1:0] LEN_MAX = 25'h1FFFFFF;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;
  localparam logic [BYTE_W-1:0] SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'h30;
  localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'h39;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [FIELD_W-1:0] field_index;
    logic [VALUE_W-1:0] value;
    logic token_start;
    logic [2:0] error_code;
    logic last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [MAXLEN_W-1:0] byte_limit;
    logic [MAXENT_W-1:0] record_limit;
    logic [BYTE_W-1:0] field_separator;
  } cfg_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t first;
    out_item_t second;
  } res_pair_t;

endpackage
`default_nettype wire

/* rtl/commit_log_record_parser_core.sv */
`default_nettype none
// Parses a stream of zero-terminated commit records, one byte per cycle while the
// output queue has room. Each byte gives at most two results: a text byte or
// timestamp, and a record status when the record closes. Results enter a
// four-entry output queue, so a byte is taken every cycle while the queue holds
// two results or fewer. Each accepted byte is first held in an input register,
// and its results are written into the queue once the queue has room; from there
// they can be taken. The rate is one byte per cycle, set by the timestamp
// accumulate (multiply by ten and add) and the output queue drain of one result
// per cycle. Configuration is written through its own port, which is always ready.
module commit_log_record_parser_core import clrp_pkg::*; #(
  parameter int unsigned FIXED_FIELDS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [MAXLEN_W-1:0]   cfg_data
);

  cfg_t cfg;
  res_pair_t res;
  logic room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.byte_limit <= BYTE_LIMIT_RESET;
      cfg.record_limit <= RECORD_LIMIT_RESET;
      cfg.field_separator <= FIELD_SEPARATOR_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BYTE_LIMIT: cfg.byte_limit <= cfg_data;
        REG_RECORD_LIMIT: cfg.record_limit <= cfg_data[MAXENT_W-1:0];
        REG_FIELD_SEPARATOR: cfg.field_separator <= cfg_data[BYTE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  clrp_parse #(
    .FIXED_FIELDS(FIXED_FIELDS)
  ) u_parse (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .cfg(cfg),
    .room(room),
    .res(res)
  );

  clrp_outq u_outq (
    .clk(clk),
    .rst(rst),
    .res(res),
    .room(room),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

endmodule
`default_nettype wire

/* rtl/clrp_parse.sv */
`default_nettype none
module clrp_parse import clrp_pkg::*; #(
  parameter int unsigned FIXED_FIELDS = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  logic      room,
  output res_pair_t res
);

  localparam logic [FIELD_W-1:0] NFIX = FIELD_W'(FIXED_FIELDS);

  logic q_valid;
  in_item_t q_item;
  logic fire;

  logic [FIELD_W-1:0] field_number, field_number_next;
  logic [LEN_W-1:0] record_length, record_length_next;
  logic [COUNT_W-1:0] record_count, record_count_next;
  logic [VALUE_W-1:0] number_accumulator, number_accumulator_next;
  logic digit_seen, digit_seen_next;
  logic author_time_bad, author_time_bad_next;
  logic committer_time_bad, committer_time_bad_next;
  logic after_space, after_space_next;
  logic halted, halted_next;

  logic [BYTE_W-1:0] b;
  logic eod, nz, is_time, is_sep, bad_cur, is_digit, overflow;
  logic [3:0] digit;
  logic [VALUE_W+3:0] acc_sum;
  logic emit0, emit1;
  out_item_t item0, item1;
  logic [2:0] err;
  logic has_err;

  assign fire = q_valid && room;
  assign in_ready = !q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_item <= in_item;
    end
  end

  assign b = q_item.data_byte;
  assign eod = q_item.end_of_data;
  assign nz = (b != TERMINATOR);
  assign is_time = (field_number < NFIX) &&
                   ((field_number == AUTHOR_FIELD) || (field_number == COMMIT_FIELD));
  assign is_sep = nz && (field_number < NFIX) && (b == cfg.field_separator);
  assign bad_cur = (field_number == AUTHOR_FIELD) ? author_time_bad : committer_time_bad;
  assign is_digit = (b >= DIGIT_ZERO) && (b <= DIGIT_NINE);
  assign digit = 4'(b - DIGIT_ZERO);
  assign acc_sum = ({4'b0, number_accumulator} << 3) + ({4'b0, number_accumulator} << 1) +
                   (VALUE_W+4)'(digit);
  assign overflow = (acc_sum[VALUE_W+3:VALUE_W] != 4'b0);

  always_comb begin
    field_number_next = field_number;
    record_length_next = record_length;
    record_count_next = record_count;
    number_accumulator_next = number_accumulator;
    digit_seen_next = digit_seen;
    author_time_bad_next = author_time_bad;
    committer_time_bad_next = committer_time_bad;
    after_space_next = after_space;
    halted_next = halted;
    emit0 = 1'b0;
    emit1 = 1'b0;
    item0 = '0;
    item1 = '0;
    err = ERR_NONE;
    has_err = 1'b0;

    if (!halted) begin
      if (nz && (record_length != LEN_MAX)) begin
        record_length_next = record_length + 1'b1;
      end
      if (is_sep) begin
        if (is_time) begin
          if (bad_cur || !digit_seen) begin
            if (field_number == AUTHOR_FIELD) begin
              author_time_bad_next = 1'b1;
            end else begin
              committer_time_bad_next = 1'b1;
            end
          end else begin
            emit0 = 1'b1;
            item0.kind = KIND_TIME;
            item0.field_index = field_number;
            item0.value = number_accumulator;
          end
        end
        number_accumulator_next = '0;
        digit_seen_next = 1'b0;
        after_space_next = 1'b1;
        field_number_next = field_number + 1'b1;
      end else if (nz && is_time) begin
        if (!bad_cur) begin
          if (is_digit && !overflow) begin
            number_accumulator_next = acc_sum[VALUE_W-1:0];
          end
          if (is_digit) begin
            digit_seen_next = 1'b1;
          end
          if (!is_digit || overflow) begin
            if (field_number == AUTHOR_FIELD) begin
              author_time_bad_next = 1'b1;
            end else begin
              committer_time_bad_next = 1'b1;
            end
          end
        end
      end else if (nz && (field_number == PARENT_FIELD)) begin
        if (b == SPACE) begin
          after_space_next = 1'b1;
        end else begin
          emit0 = 1'b1;
          item0.kind = KIND_TEXT;
          item0.field_index = field_number;
          item0.value = VALUE_W'(b);
          item0.token_start = after_space;
          after_space_next = 1'b0;
        end
      end else if (nz) begin
        emit0 = 1'b1;
        item0.kind = KIND_TEXT;
        item0.field_index = field_number;
        item0.value = VALUE_W'(b);
      end

      if ((!nz || eod) && (record_length_next != '0)) begin
        has_err = 1'b1;
        priority if (record_length_next > LEN_W'(cfg.byte_limit)) begin
          err = ERR_TOO_LONG;
        end else if (record_count >= COUNT_W'(cfg.record_limit)) begin
          err = ERR_TOO_MANY;
        end else if (field_number_next < NFIX) begin
          err = ERR_TOO_FEW;
        end else if (author_time_bad_next) begin
          err = ERR_AUTHOR_TIME;
        end else if (committer_time_bad_next) begin
          err = ERR_COMMIT_TIME;
        end else begin
          has_err = 1'b0;
        end
        emit1 = 1'b1;
        if (has_err) begin
          item1.kind = KIND_ERROR;
          item1.error_code = err;
          halted_next = 1'b1;
        end else begin
          item1.kind = KIND_ACCEPT;
          record_count_next = record_count + 1'b1;
        end
        field_number_next = '0;
        record_length_next = '0;
        number_accumulator_next = '0;
        digit_seen_next = 1'b0;
        author_time_bad_next = 1'b0;
        committer_time_bad_next = 1'b0;
        after_space_next = 1'b1;
      end
    end

    if (eod) begin
      field_number_next = '0;
      record_length_next = '0;
      number_accumulator_next = '0;
      digit_seen_next = 1'b0;
      author_time_bad_next = 1'b0;
      committer_time_bad_next = 1'b0;
      after_space_next = 1'b1;
      record_count_next = '0;
      halted_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_number <= '0;
      record_length <= '0;
      record_count <= '0;
      number_accumulator <= '0;
      digit_seen <= 1'b0;
      author_time_bad <= 1'b0;
      committer_time_bad <= 1'b0;
      after_space <= 1'b1;
      halted <= 1'b0;
    end else if (fire) begin
      field_number <= field_number_next;
      record_length <= record_length_next;
      record_count <= record_count_next;
      number_accumulator <= number_accumulator_next;
      digit_seen <= digit_seen_next;
      author_time_bad <= author_time_bad_next;
      committer_time_bad <= committer_time_bad_next;
      after_space <= after_space_next;
      halted <= halted_next;
    end
  end

  always_comb begin
    res = '0;
    if (fire) begin
      unique case ({emit0, emit1})
        2'b11: begin
          res.count = 2'd2;
          res.first = item0;
          res.second = item1;
          res.second.last_of_run = 1'b1;
        end
        2'b10: begin
          res.count = 2'd1;
          res.first = item0;
          res.first.last_of_run = 1'b1;
        end
        2'b01: begin
          res.count = 2'd1;
          res.first = item1;
          res.first.last_of_run = 1'b1;
        end
        default: begin
          res.count = 2'd0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/clrp_outq.sv */
`default_nettype none
module clrp_outq import clrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t res,
  output logic      room,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  out_item_t entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic pop;

  assign out_valid = (count != '0);
  assign out_item = entries[rd_ptr];
  assign pop = out_valid && out_ready;
  assign room = (count <= QCNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (res.count != 2'd0) begin
      entries[wr_ptr] <= res.first;
    end
    if (res.count == 2'd2) begin
      entries[wr_ptr + 1'b1] <= res.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(res.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count <= count + QCNT_W'(res.count) - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/clrp_checker.sv */
`default_nettype none
module clrp_checker import clrp_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("Result item changed while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result item shown right after reset.");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("Input not ready right after reset.");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_ACCEPT || out_item.kind == KIND_ERROR) |->
      out_item.field_index == '0 && out_item.value == '0 && out_item.last_of_run)
    else $error("Record status item carries stray fields.");

  a_time_field: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.kind == KIND_TIME |->
      !out_item.token_start && out_item.error_code == ERR_NONE &&
      (out_item.field_index == AUTHOR_FIELD || out_item.field_index == COMMIT_FIELD))
    else $error("Timestamp item from a field that is not a time field.");

endmodule

bind commit_log_record_parser_core clrp_checker u_clrp_checker (.*);
`default_nettype wire

/* sim/commit_log_record_parser_core_tb.sv */
`timescale 1ns / 100ps

module commit_log_record_parser_core_tb;
  import clrp_pkg::*;

  localparam int FIELDS = 10;
  localparam int HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_PHASES = 8;

  localparam int PHASE_BYTES [NUM_PHASES] = '{16777215, 40, 0, 65536, 24, 16777215, 50, 65536};
  localparam int PHASE_RECS [NUM_PHASES] = '{1048575, 3, 1048575, 0, 2, 5, 20, 4096};
  localparam int PHASE_SEP [NUM_PHASES] = '{255, 31, 124, 31, 0, 31, 1, 124};
  localparam int PHASE_MODE [NUM_PHASES] = '{0, 1, 2, 3, 0, 1, 2, 3};
  localparam int PHASE_ITEMS [NUM_PHASES] = '{80, 70, 40, 40, 60, 80, 70, 60};
  localparam int SEND_IDLE [4] = '{0, 75, 0, 14};
  localparam int RECV_STALL [4] = '{0, 0, 75, 14};

  class record_scoreboard;
    logic [MAXLEN_W-1:0] max_bytes;
    logic [MAXENT_W-1:0] max_recs;
    logic [BYTE_W-1:0] sep;
    logic [FIELD_W-1:0] fld;
    logic [LEN_W-1:0] rec_len;
    logic [COUNT_W-1:0] rec_count;
    logic [VALUE_W-1:0] acc;
    bit digit_seen;
    bit author_bad;
    bit commit_bad;
    bit after_space;
    bit halted;
    out_item_t pending_q[$];
    int failures;
    int results;
    int dropped;
    int accepted;
    int rejected;
    int stamps;
    logic [4:0] codes_seen;

    function new();
      max_bytes = BYTE_LIMIT_RESET;
      max_recs = RECORD_LIMIT_RESET;
      sep = FIELD_SEPARATOR_RESET;
      clear_record();
      rec_count = '0;
      halted = 1'b0;
      failures = 0;
      results = 0;
      dropped = 0;
      accepted = 0;
      rejected = 0;
      stamps = 0;
      codes_seen = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [MAXLEN_W-1:0] data);
      case (idx)
        REG_BYTE_LIMIT: max_bytes = data;
        REG_RECORD_LIMIT: max_recs = data[MAXENT_W-1:0];
        REG_FIELD_SEPARATOR: sep = data[BYTE_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void clear_record();
      fld = '0;
      rec_len = '0;
      acc = '0;
      digit_seen = 1'b0;
      author_bad = 1'b0;
      commit_bad = 1'b0;
      after_space = 1'b1;
    endfunction

    function bit is_stamp_field(logic [FIELD_W-1:0] f);
      return (f < FIELDS) && (f == AUTHOR_FIELD || f == COMMIT_FIELD);
    endfunction

    function void queue_result(logic [1:0] k, logic [FIELD_W-1:0] f, logic [VALUE_W-1:0] v,
                               logic tok, logic [2:0] code);
      out_item_t r;
      r = '0;
      r.kind = k;
      r.field_index = f;
      r.value = v;
      r.token_start = tok;
      r.error_code = code;
      if (k == KIND_TIME) stamps++;
      pending_q.insert(pending_q.size(), r);
    endfunction

    function void close_record();
      logic [2:0] code;
      bit failed;
      if (rec_len == 0) return;
      failed = 1'b1;
      code = ERR_NONE;
      if (rec_len > max_bytes) code = ERR_TOO_LONG;
      else if (rec_count >= max_recs) code = ERR_TOO_MANY;
      else if (fld < FIELDS) code = ERR_TOO_FEW;
      else if (author_bad) code = ERR_AUTHOR_TIME;
      else if (commit_bad) code = ERR_COMMIT_TIME;
      else failed = 1'b0;
      if (failed) begin
        queue_result(KIND_ERROR, '0, '0, 1'b0, code);
        halted = 1'b1;
        rejected++;
        codes_seen[code] = 1'b1;
      end else begin
        queue_result(KIND_ACCEPT, '0, '0, 1'b0, ERR_NONE);
        rec_count++;
        accepted++;
      end
      clear_record();
    endfunction

    function void mark_stamp_bad(logic [FIELD_W-1:0] f);
      if (f == AUTHOR_FIELD) author_bad = 1'b1;
      else commit_bad = 1'b1;
    endfunction

    // Returns 0 when the byte is discarded while waiting for end of data.
    function bit note_input(in_item_t it);
      logic [BYTE_W-1:0] b;
      logic [FIELD_W-1:0] f;
      logic [VALUE_W-1:0] digit;
      logic [VALUE_W-1:0] room;
      bit bad;
      int first;
      b = it.data_byte;
      first = pending_q.size();
      if (halted) begin
        if (it.end_of_data) begin
          clear_record();
          rec_count = '0;
          halted = 1'b0;
          return 1'b1;
        end
        dropped++;
        return 1'b0;
      end
      if (b != TERMINATOR) begin
        f = fld;
        if (rec_len != LEN_MAX) rec_len++;
        if (f < FIELDS && b == sep) begin
          if (is_stamp_field(f)) begin
            bad = (f == AUTHOR_FIELD) ? author_bad : commit_bad;
            if (!digit_seen) bad = 1'b1;
            if (bad) mark_stamp_bad(f);
            else queue_result(KIND_TIME, f, acc, 1'b0, ERR_NONE);
          end
          acc = '0;
          digit_seen = 1'b0;
          after_space = 1'b1;
          fld = f + 4'd1;
        end else if (is_stamp_field(f)) begin
          bad = (f == AUTHOR_FIELD) ? author_bad : commit_bad;
          if (!bad) begin
            if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
              digit = VALUE_W'(b - DIGIT_ZERO);
              room = ({VALUE_W{1'b1}} - digit) / 63'd10;
              if (acc > room) bad = 1'b1;
              else acc = acc * 63'd10 + digit;
              digit_seen = 1'b1;
            end else begin
              bad = 1'b1;
            end
            if (bad) mark_stamp_bad(f);
          end
        end else if (f == PARENT_FIELD) begin
          if (b == SPACE) begin
            after_space = 1'b1;
          end else begin
            queue_result(KIND_TEXT, f, VALUE_W'(b), after_space, ERR_NONE);
            after_space = 1'b0;
          end
        end else begin
          queue_result(KIND_TEXT, f, VALUE_W'(b), 1'b0, ERR_NONE);
        end
      end
      if (b == TERMINATOR || it.end_of_data) close_record();
      if (it.end_of_data) begin
        clear_record();
        rec_count = '0;
        halted = 1'b0;
      end
      if (pending_q.size() > first) begin
        pending_q[pending_q.size() - 1].last_of_run = 1'b1;
      end
      return 1'b1;
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      results++;
      if (pending_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("Unexpected item: kind=%0d field=%0d value=%0d token_start=%0b error_code=%0d",
                   got.kind, got.field_index, got.value, got.token_start, got.error_code);
        return;
      end
      want = pending_q.pop_front();
      if (got.kind !== want.kind || got.field_index !== want.field_index ||
          got.value !== want.value || got.token_start !== want.token_start ||
          got.error_code !== want.error_code || got.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= 10) begin
          $display("Mismatch on item %0d:", results);
          $display("  expected kind=%0d field=%0d value=%0d token_start=%0b error_code=%0d last=%0b",
                   want.kind, want.field_index, want.value, want.token_start, want.error_code,
                   want.last_of_run);
          $display("  actual   kind=%0d field=%0d value=%0d token_start=%0b error_code=%0d last=%0b",
                   got.kind, got.field_index, got.value, got.token_start, got.error_code,
                   got.last_of_run);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [MAXLEN_W-1:0] cfg_data;

  record_scoreboard sb;
  in_item_t stream_q[$];
  logic [BYTE_W-1:0] sep_now = FIELD_SEPARATOR_RESET;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int bytes_sent = 0;

  commit_log_record_parser_core #(.FIXED_FIELDS(FIELDS)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_item);
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void add_item(logic [7:0] b, logic eod);
    in_item_t it;
    it.data_byte = b;
    it.end_of_data = eod;
    stream_q.insert(stream_q.size(), it);
  endfunction

  function automatic void add_byte(logic [7:0] b);
    add_item(b, 1'b0);
  endfunction

  function automatic void add_digit();
    add_byte(DIGIT_ZERO + 8'($urandom_range(9)));
  endfunction

  function automatic logic [7:0] text_byte(bit no_space);
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1)); while (b == sep_now || (no_space && b == SPACE));
    return b;
  endfunction

  // Mostly well-formed records with random content; some are cut short, some are
  // plain noise, and the stream always ends with an end-of-data item.
  function automatic void build_stream();
    int nrec;
    int stop_at;
    int mode;
    int ntok;
    string big;
    logic [7:0] b;
    stream_q.delete();
    nrec = $urandom_range(4, 1);
    for (int r = 0; r < nrec; r++) begin
      if ($urandom_range(15) == 0) add_byte(TERMINATOR);
      if ($urandom_range(15) == 0) begin
        repeat ($urandom_range(8, 1)) add_byte(8'($urandom_range(255)));
      end else begin
        stop_at = ($urandom_range(7) == 0) ? $urandom_range(FIELDS) : FIELDS;
        for (int f = 0; f < FIELDS; f++) begin
          if (f == PARENT_FIELD) begin
            ntok = $urandom_range(3);
            if ($urandom_range(3) == 0) add_byte(SPACE);
            for (int t = 0; t < ntok; t++) begin
              if (t > 0) repeat ($urandom_range(2, 1)) add_byte(SPACE);
              repeat ($urandom_range(4, 1)) add_byte(text_byte(1'b1));
            end
            if ($urandom_range(3) == 0) add_byte(SPACE);
          end else if (f == AUTHOR_FIELD || f == COMMIT_FIELD) begin
            mode = $urandom_range(15);
            big = (mode == 1) ? "9223372036854775807" :
                  (mode == 2) ? "9223372036854775808" : "";
            for (int i = 0; i < big.len(); i++) add_byte(big[i]);
            if (mode == 3) begin
              repeat ($urandom_range(25, 20)) add_digit();
            end else if (mode == 4) begin
              repeat ($urandom_range(3)) add_digit();
              do b = text_byte(1'b0); while (b >= DIGIT_ZERO && b <= DIGIT_NINE);
              add_byte(b);
              repeat ($urandom_range(3)) add_digit();
            end else if (mode > 4) begin
              repeat ($urandom_range(12, 1)) add_digit();
            end
          end else begin
            repeat ($urandom_range(3)) add_byte(text_byte(1'b0));
          end
          if (f == stop_at) break;
          add_byte(sep_now);
        end
        if (stop_at == FIELDS) repeat ($urandom_range(6)) add_byte(8'($urandom_range(255, 1)));
      end
      if (r < nrec - 1) add_byte(TERMINATOR);
    end
    mode = $urandom_range(2);
    if (mode == 0 && stream_q.size() != 0) begin
      stream_q[stream_q.size() - 1].end_of_data = 1'b1;
    end else if (mode == 1) begin
      add_item(TERMINATOR, 1'b1);
    end else begin
      add_item(8'($urandom_range(255)), 1'b1);
    end
  endfunction

  task automatic send_item(input in_item_t it);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
    void'(sb.note_input(it));
  endtask

  task automatic send_queue();
    foreach (stream_q[i]) begin
      send_item(stream_q[i]);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MAXLEN_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  initial begin
    int phase_start;
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Empty record, a minimal accepted record with parent tokens, zero and short
    // timestamps and a separator in the body, then a short record rejected for too
    // few fields whose trailing bytes are dropped until end of data.
    stream_q.delete();
    add_byte(TERMINATOR);
    add_byte(sep_now);
    add_byte(SPACE);
    add_byte("a");
    add_byte("b");
    add_byte(SPACE);
    add_byte(8'hC1);
    add_byte(sep_now);
    add_byte("7");
    add_byte(sep_now);
    add_byte(sep_now);
    add_byte(sep_now);
    add_byte("0");
    add_byte(sep_now);
    repeat (4) add_byte(sep_now);
    add_byte(8'hFF);
    add_byte(sep_now);
    add_byte(TERMINATOR);
    add_byte("q");
    add_byte(TERMINATOR);
    add_byte(8'h55);
    add_item(TERMINATOR, 1'b1);
    send_queue();

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      write_reg(REG_BYTE_LIMIT, MAXLEN_W'(PHASE_BYTES[p]));
      write_reg(REG_RECORD_LIMIT, MAXLEN_W'(PHASE_RECS[p]));
      write_reg(REG_FIELD_SEPARATOR, MAXLEN_W'(PHASE_SEP[p]));
      cfg_valid <= 1'b0;
      sep_now = 8'(PHASE_SEP[p]);
      idle_pct = SEND_IDLE[PHASE_MODE[p]];
      stall_pct <= RECV_STALL[PHASE_MODE[p]];
      // A long output stall fills the block up, with and without idling on the input.
      if (p == 0 || p == 5) hold_reqs <= hold_reqs + 1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_ITEMS[p]) begin
        build_stream();
        send_queue();
      end
    end
    drain();

    $display("Run covered %0d input items (%0d dropped after errors) and %0d results, %0d timestamps.",
             bytes_sent, sb.dropped, sb.results, sb.stamps);
    $display("Records: %0d accepted, %0d rejected, error codes seen %05b, %0d mismatches.",
             sb.accepted, sb.rejected, sb.codes_seen, sb.failures);
    if (sb.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
